// File: hdl/swf_pkg.sv
// shared types, widths and codes for the staggered window fir
// no dependencies; compile first

package swf_pkg;

	localparam int unsigned CMD_W = 2;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned WV_W = 16;
	localparam int unsigned SMP_W = 16;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned SUM_W = 48;
	localparam int unsigned FRAC_W = 16;

	localparam int unsigned STAGES_DEF = 4;
	localparam int unsigned MAX_WINDOW_DEF = 4096;
	localparam int unsigned LEN_RESET = 4096;
	localparam int unsigned LEN_MIN = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_LOAD,
		OP_RESTART,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [IDX_W-1:0] idx;
		logic [WV_W-1:0] wval;
		logic signed [SMP_W-1:0] smp;
	} op_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_ISSUE,
		BS_DRAIN,
		BS_STAGGER
	} back_state_t;

endpackage

// File: hdl/swf_item_if.sv
// input channel of the staggered window fir: valid/ready plus item fields
// depends on swf_pkg

interface swf_item_if import swf_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] weight_index;
	logic [WV_W-1:0] weight_value;
	logic signed [SMP_W-1:0] sample;

	modport source (output valid, output cmd, output weight_index, output weight_value,
		output sample, input ready);
	modport sink (input valid, input cmd, input weight_index, input weight_value,
		input sample, output ready);
endinterface

// File: hdl/swf_result_if.sv
// result channel of the staggered window fir: valid/ready plus result fields
// depends on swf_pkg

interface swf_result_if import swf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SMP_W-1:0] filtered;
	logic fresh;

	modport source (output valid, output filtered, output fresh, input ready);
	modport sink (input valid, input filtered, input fresh, output ready);
endinterface

// File: hdl/staggered_window_fir.sv
// Staggered window FIR. Every input item yields exactly one result item. A
// sample item runs STAGES accumulators, each at its own phase of a window of
// Q0.16 weights; an accumulator that passes the window end refreshes the held
// output (sum >> 16, floored and saturated) and restarts at phase zero. A front
// end classifies items into a two-entry op queue, so the input keeps
// accepting until the queue is full while the back end works or the result
// register waits. In the back end a sample makes one weight read per stage
// on the single read port of the weight ram, pipelined through read,
// multiply and accumulate, then drains the pipeline. A weight load or an
// unused command is done in the cycle it leaves the queue. A restart sets
// one stage phase per cycle, k*L/STAGES taken from a running k*L by a
// constant reciprocal multiply.
// Weights are undefined until loaded; there is no clearing pass after reset.
// The window length register (cfg port) may be written only when idle.
// depends on swf_pkg, swf_item_if, swf_result_if, swf_ram, swf_front,
// swf_queue and swf_back

module staggered_window_fir import swf_pkg::*; #(
	parameter int unsigned STAGES = STAGES_DEF,
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input logic clk,
	input logic arst_n,
	swf_item_if.sink item_ch,
	swf_result_if.source result_ch,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LEN_W-1:0] window_length
);

	localparam int unsigned AW = $clog2(MAX_WINDOW);

	logic push_valid;
	logic push_ready;
	op_t push_op;
	logic pop_valid;
	logic pop;
	op_t pop_op;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WV_W-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [WV_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	swf_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.item(item_ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op(push_op)
	);

	swf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op(push_op),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_op(pop_op)
	);

	swf_back #(
		.STAGES(STAGES),
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid),
		.cfg_len(window_length),
		.op_valid(pop_valid),
		.op(pop_op),
		.op_pop(pop),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.result(result_ch)
	);

	swf_ram #(
		.WIDTH(WV_W),
		.DEPTH(MAX_WINDOW)
	) u_weights (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// back end never takes an op the queue does not hold
	a_pop_has_op: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("op popped from empty queue");

	// out-of-range loads must be dropped by the front end
	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_op.kind == OP_LOAD) |-> (32'(push_op.idx) < MAX_WINDOW))
		else $error("weight load beyond store reached the queue");

	// a weight write only happens in the cycle its op leaves the queue
	a_write_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (pop && pop_op.kind == OP_LOAD))
		else $error("weight write without a load op");

endmodule

// File: hdl/swf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module swf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/swf_front.sv
// front end: takes items off the input channel and turns them into queue ops
// depends on swf_pkg and swf_item_if

module swf_front import swf_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	swf_item_if.sink item,
	output logic push_valid,
	input logic push_ready,
	output op_t push_op
);

	assign push_valid = item.valid;
	assign item.ready = push_ready;

	always_comb begin
		push_op.idx = item.weight_index;
		push_op.wval = item.weight_value;
		push_op.smp = item.sample;
		case (item.cmd)
			CMD_SAMPLE: begin
				push_op.kind = OP_SAMPLE;
			end
			CMD_LOAD: begin
				// loads past the end of the weight store are dropped
				if (32'(item.weight_index) < MAX_WINDOW) begin
					push_op.kind = OP_LOAD;
				end else begin
					push_op.kind = OP_NOP;
				end
			end
			CMD_RESTART: begin
				push_op.kind = OP_RESTART;
			end
			default: begin
				push_op.kind = OP_NOP;
			end
		endcase
	end

endmodule

// File: hdl/swf_queue.sv
// small op queue between the front end and the execution back end
// depends on swf_pkg

module swf_queue import swf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input op_t push_op,
	output logic pop_valid,
	input logic pop,
	output op_t pop_op
);

	localparam int unsigned PTW = $clog2(DEPTH);
	localparam int unsigned CTW = $clog2(DEPTH + 1);

	op_t mem_q [DEPTH];
	logic [PTW-1:0] wr_ptr_q;
	logic [PTW-1:0] rd_ptr_q;
	logic [CTW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CTW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_op = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CTW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CTW'(1);
			end
		end
	end

endmodule

// File: hdl/swf_back.sv
// back end: runs queued ops - per-stage multiply-accumulate over the shared
// weight ram, weight loads, and the restart stagger; holds the result register
// depends on swf_pkg and swf_result_if

module swf_back import swf_pkg::*; #(
	parameter int unsigned STAGES = STAGES_DEF,
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int unsigned AW = $clog2(MAX_WINDOW)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [LEN_W-1:0] cfg_len,
	input logic op_valid,
	input op_t op,
	output logic op_pop,
	output logic ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [WV_W-1:0] ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input logic [WV_W-1:0] ram_rdata,
	swf_result_if.source result
);

	localparam int unsigned PW = AW;
	localparam int unsigned LW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned CW = PW + 1;
	localparam int unsigned SW = (STAGES > 1) ? $clog2(STAGES) : 1;
	// running k*L for the stagger, and the reciprocal that divides it by STAGES
	localparam int unsigned NW = $clog2((STAGES - 1) * MAX_WINDOW + 2);
	localparam int unsigned RL = $clog2(STAGES);
	localparam int unsigned RSH = NW + RL;
	localparam int unsigned PRW = 2 * NW + 1;
	localparam longint unsigned RECIP = ((longint'(1) << RSH) + STAGES - 1) / STAGES;
	localparam int unsigned PROD_W = WV_W + SMP_W + 1;
	localparam int unsigned HI_W = SUM_W - (FRAC_W + SMP_W - 1);
	localparam int unsigned RST_LEN = (LEN_RESET < LEN_MIN) ? LEN_MIN :
		((LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET);
	localparam logic [SW-1:0] LAST = SW'(STAGES - 1);

	back_state_t state_q, state_d;

	logic [LEN_W-1:0] len_q;
	logic [31:0] len_wide;
	logic [LW-1:0] len_eff;

	logic [PW-1:0] phase_q [STAGES];
	logic signed [SUM_W-1:0] sum_q [STAGES];
	logic signed [SMP_W-1:0] held_q;
	logic fresh_item_q;
	logic signed [SMP_W-1:0] smp_q;
	logic [SW-1:0] k_q;

	logic rd_v_s1;
	logic [SW-1:0] k_s1;
	logic [PW-1:0] phase_s1;
	logic mul_v_s2;
	logic [SW-1:0] k_s2;
	logic [PW-1:0] phase_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic [NW-1:0] num_q;
	logic [PRW-1:0] stg_prod;

	logic res_valid_q;
	logic signed [SMP_W-1:0] res_filtered_q;
	logic res_fresh_q;

	logic slot_free;
	logic issue;
	logic stg_en;
	logic acc_last;
	logic stg_last;
	logic pop_direct;
	logic res_load;
	logic signed [SMP_W-1:0] res_filt_d;
	logic res_fresh_d;

	logic signed [SUM_W-1:0] prod_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic [CW-1:0] ph_inc;
	logic wrap;
	logic [HI_W-1:0] sum_hi;
	logic signed [SMP_W-1:0] conv;

	logic st_wr;
	logic [SW-1:0] st_idx;
	logic [PW-1:0] st_phase_d;
	logic signed [SUM_W-1:0] st_sum_d;

	// effective window length, clamped to the legal range
	always_comb begin
		if (32'(len_q) < LEN_MIN) begin
			len_wide = LEN_MIN;
		end else if (32'(len_q) > MAX_WINDOW) begin
			len_wide = MAX_WINDOW;
		end else begin
			len_wide = 32'(len_q);
		end
	end
	assign len_eff = len_wide[LW-1:0];

	assign slot_free = !res_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (op_valid && slot_free) begin
					if (op.kind == OP_SAMPLE) begin
						state_d = BS_ISSUE;
					end else if (op.kind == OP_RESTART) begin
						state_d = BS_STAGGER;
					end
				end
			end
			BS_ISSUE: begin
				if (k_q == LAST) begin
					state_d = BS_DRAIN;
				end
			end
			BS_DRAIN: begin
				if (mul_v_s2 && k_s2 == LAST) begin
					state_d = BS_IDLE;
				end
			end
			BS_STAGGER: begin
				if (k_q == LAST) begin
					state_d = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_comb begin
		op_pop = 1'b0;
		issue = 1'b0;
		stg_en = 1'b0;
		case (state_q)
			BS_IDLE: begin
				op_pop = op_valid && slot_free;
			end
			BS_ISSUE: begin
				issue = 1'b1;
			end
			BS_STAGGER: begin
				stg_en = 1'b1;
			end
			default: begin
				op_pop = 1'b0;
			end
		endcase
	end

	assign ram_we = op_pop && (op.kind == OP_LOAD);
	assign ram_waddr = AW'(op.idx);
	assign ram_wdata = op.wval;
	assign ram_raddr = phase_q[k_q];

	// accumulate stage: add the product, advance the phase, close the window
	assign prod_ext = {{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign sum_new = sum_q[k_s2] + prod_ext;
	assign ph_inc = CW'(phase_s2) + CW'(1);
	assign wrap = (ph_inc >= CW'(len_eff));
	assign sum_hi = sum_new[SUM_W-1:FRAC_W+SMP_W-1];

	always_comb begin
		if ((&sum_hi) || !(|sum_hi)) begin
			conv = sum_new[FRAC_W+SMP_W-1:FRAC_W];
		end else if (sum_new[SUM_W-1]) begin
			conv = SAT_MIN;
		end else begin
			conv = SAT_MAX;
		end
	end

	// stagger step: phase k = floor(k*L/stages), exact for every k*L that fits num_q
	assign stg_prod = PRW'(num_q) * PRW'(RECIP);

	assign acc_last = mul_v_s2 && (k_s2 == LAST);
	assign stg_last = stg_en && (k_q == LAST);
	assign pop_direct = op_pop && (op.kind == OP_LOAD || op.kind == OP_NOP);
	assign res_load = pop_direct || acc_last || stg_last;

	always_comb begin
		if (acc_last) begin
			res_filt_d = wrap ? conv : held_q;
			res_fresh_d = fresh_item_q || wrap;
		end else begin
			res_filt_d = held_q;
			res_fresh_d = 1'b0;
		end
	end

	always_comb begin
		st_wr = mul_v_s2 || stg_en;
		st_idx = stg_en ? k_q : k_s2;
		if (stg_en) begin
			st_phase_d = PW'(stg_prod >> RSH);
			st_sum_d = '0;
		end else if (wrap) begin
			st_phase_d = '0;
			st_sum_d = '0;
		end else begin
			st_phase_d = ph_inc[PW-1:0];
			st_sum_d = sum_new;
		end
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam int unsigned RST_PHASE = (g * RST_LEN) / STAGES;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q[g] <= PW'(RST_PHASE);
				sum_q[g] <= '0;
			end else if (st_wr && st_idx == SW'(g)) begin
				phase_q[g] <= st_phase_d;
				sum_q[g] <= st_sum_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			len_q <= LEN_W'(LEN_RESET);
			held_q <= '0;
			fresh_item_q <= 1'b0;
			k_q <= '0;
			rd_v_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				len_q <= cfg_len;
			end
			if (mul_v_s2 && wrap) begin
				held_q <= conv;
			end
			if (op_pop) begin
				fresh_item_q <= 1'b0;
			end else if (mul_v_s2 && wrap) begin
				fresh_item_q <= 1'b1;
			end
			if (op_pop) begin
				k_q <= '0;
			end else if (issue || stg_en) begin
				k_q <= (k_q == LAST) ? '0 : k_q + SW'(1);
			end
			rd_v_s1 <= issue;
			mul_v_s2 <= rd_v_s1;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			smp_q <= op.smp;
			num_q <= '0;
		end else if (stg_en) begin
			num_q <= num_q + NW'(len_eff);
		end
		k_s1 <= k_q;
		phase_s1 <= phase_q[k_q];
		k_s2 <= k_s1;
		phase_s2 <= phase_s1;
		prod_s2 <= $signed({1'b0, ram_rdata}) * smp_q;
		if (res_load) begin
			res_filtered_q <= res_filt_d;
			res_fresh_q <= res_fresh_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.filtered = res_filtered_q;
	assign result.fresh = res_fresh_q;

endmodule

// File: tb/sv/tb_staggered_window_fir.sv
`timescale 1ns / 100ps
// self-checking bench for staggered_window_fir: a directed table, then random phases over
// many window lengths, results checked against typed rows or a model of the accumulators
// depends on swf_pkg, swf_item_if, swf_result_if and the staggered_window_fir rtl

module tb_staggered_window_fir;
	import swf_pkg::*;

	localparam int unsigned NSTAGE = STAGES_DEF;
	localparam int unsigned NWIN = MAX_WINDOW_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned LEN_TOP = (1 << LEN_W) - 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned NROWS = 32;

	typedef struct packed {
		logic signed [SMP_W-1:0] filtered;
		logic fresh;
	} fir_out_t;

	typedef struct packed {
		logic cfg;
		logic [LEN_W-1:0] len;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [WV_W-1:0] wval;
		logic signed [SMP_W-1:0] smp;
		logic typed;
		logic signed [SMP_W-1:0] want_f;
		logic want_fresh;
	} dir_row_t;

	// cfg, len, cmd, idx, wval, smp, typed, filtered, fresh
	dir_row_t dir_rows [0:NROWS-1] = '{
		// reset length 4096: stages sit at 0, 1024, 2048, 3072
		'{1'b0, 13'd0, CMD_LOAD, 12'd0, 16'hffff, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd1024, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd2048, 16'h0001, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd3072, 16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd4095, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'hfff, 16'hffff, 16'h7fff, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_UNUSED, 12'hfff, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_RESTART, 12'hfff, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b0},
		// shrink without restart: three stages past the end complete together
		'{1'b1, 13'd4, CMD_SAMPLE, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b1, 16'hc000, 1'b1},
		'{1'b0, 13'd0, CMD_LOAD, 12'd1, 16'hffff, 16'h0000, 1'b1, 16'hc000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd2, 16'hffff, 16'h0000, 1'b1, 16'hc000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd3, 16'hffff, 16'h0000, 1'b1, 16'hc000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
		// length below the floor, negative saturation
		'{1'b1, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_RESTART, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
		// length above the ceiling
		'{1'b1, 13'h1fff, CMD_SAMPLE, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_RESTART, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h0001, 1'b0, 16'h0000, 1'b0},
		// length not divisible by the stage count
		'{1'b1, 13'd5, CMD_SAMPLE, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_RESTART, 12'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_LOAD, 12'd4, 16'h0001, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 13'd0, CMD_SAMPLE, 12'd0, 16'h0000, 16'hffff, 1'b0, 16'h0000, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [LEN_W-1:0] window_length;

	swf_item_if item_ch ();
	swf_result_if result_ch ();

	staggered_window_fir dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_ch(item_ch),
		.result_ch(result_ch),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.window_length(window_length)
	);

	// model state
	logic [WV_W-1:0] wgt_mem [NWIN];
	bit wgt_loaded [NWIN];
	logic signed [SUM_W-1:0] acc_sum [NSTAGE];
	int unsigned acc_phase [NSTAGE];
	logic signed [SMP_W-1:0] held_val;
	logic [LEN_W-1:0] len_reg;

	fir_out_t expected_outs [$];
	fir_out_t head_out;

	int errors = 0;
	int reported = 0;
	int items_sent = 0;
	int n_by_cmd [4] = '{0, 0, 0, 0};
	int n_cfg = 0;
	int n_results = 0;
	int n_fresh = 0;
	int burst_left = 0;
	int unsigned cycle_count = 0;
	logic [5:0] stall_tick;
	logic [1:0] stall_mode;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_outs.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int unsigned win_len();
		if (len_reg < LEN_MIN)
			return LEN_MIN;
		if (len_reg > NWIN)
			return NWIN;
		return 32'(len_reg);
	endfunction

	task automatic restagger();
		int unsigned span;
		span = win_len();
		for (int k = 0; k < NSTAGE; k++) begin
			acc_sum[k] = '0;
			acc_phase[k] = k * span / NSTAGE;
		end
	endtask

	// one item through the accumulators, returns the result it yields
	task automatic fir_step(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
		input logic [WV_W-1:0] wval, input logic signed [SMP_W-1:0] smp,
		output fir_out_t res);
		int unsigned span;
		int unsigned p;
		logic signed [SUM_W-1:0] prod;
		logic signed [SUM_W-1:0] scaled;
		res.fresh = 1'b0;
		case (cmd)
			CMD_SAMPLE: begin
				span = win_len();
				for (int k = 0; k < NSTAGE; k++) begin
					p = acc_phase[k] % NWIN;
					prod = $signed({1'b0, wgt_mem[p]}) * smp;
					acc_sum[k] = acc_sum[k] + prod;
					p++;
					// later stages overwrite the held value when several complete
					if (p >= span) begin
						scaled = acc_sum[k] >>> FRAC_W;
						if (scaled > SAT_MAX)
							held_val = SAT_MAX;
						else if (scaled < SAT_MIN)
							held_val = SAT_MIN;
						else
							held_val = scaled[SMP_W-1:0];
						acc_sum[k] = '0;
						p = 0;
						res.fresh = 1'b1;
					end
					acc_phase[k] = p;
				end
			end
			CMD_LOAD: begin
				wgt_mem[idx] = wval;
				wgt_loaded[idx] = 1'b1;
			end
			CMD_RESTART: begin
				restagger();
			end
			default: begin
			end
		endcase
		res.filtered = held_val;
	endtask

	function automatic logic [WV_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'hffff;
			1: return 16'h0000;
			2: return 16'h8000;
			default: return WV_W'($urandom_range(0, 16'hffff) >> $urandom_range(0, 10));
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return SMP_W'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	// sender runs in bursts with idle gaps between them
	task automatic pace();
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(30, 60);
			else
				burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
		input logic [WV_W-1:0] wval, input logic [SMP_W-1:0] smp, input logic typed,
		input logic signed [SMP_W-1:0] want_f, input logic want_fresh);
		fir_out_t got;
		pace();
		item_ch.valid <= 1'b1;
		item_ch.cmd <= cmd;
		item_ch.weight_index <= idx;
		item_ch.weight_value <= wval;
		item_ch.sample <= smp;
		do @(posedge clk); while (!item_ch.ready);
		fir_step(cmd, idx, wval, smp, got);
		if (typed) begin
			got.filtered = want_f;
			got.fresh = want_fresh;
		end
		expected_outs.push_back(got);
		items_sent++;
		n_by_cmd[cmd]++;
	endtask

	// a weight is never read before it was loaded
	task automatic load_missing();
		int unsigned p;
		for (int k = 0; k < NSTAGE; k++) begin
			p = acc_phase[k] % NWIN;
			if (!wgt_loaded[p])
				send_item(CMD_LOAD, IDX_W'(p), pick_weight(),
					SMP_W'($urandom_range(0, 16'hffff)), 1'b0, '0, 1'b0);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (expected_outs.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		window_length <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		len_reg = value;
		n_cfg++;
	endtask

	task automatic note_mismatch(input string what, input fir_out_t want, input fir_out_t got);
		errors++;
		if (reported < 10) begin
			reported++;
			$display("%s at cycle %0d: got filtered %0d fresh %0b, expected filtered %0d fresh %0b",
				what, cycle_count, got.filtered, got.fresh, want.filtered, want.fresh);
		end
	endtask

	// receiver switches between stall patterns whenever stall_tick wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_tick <= '0;
			stall_mode <= '0;
		end else begin
			stall_tick <= stall_tick + 1'b1;
			if (stall_tick == '1)
				stall_mode <= 2'($urandom_range(0, 3));
			case (stall_mode)
				2'd0: result_ch.ready <= 1'b1;
				2'd1: result_ch.ready <= 1'($urandom_range(0, 1));
				2'd2: result_ch.ready <= ($urandom_range(0, 4) == 0);
				default: result_ch.ready <= (stall_tick[2:0] != 3'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_results++;
			if (result_ch.fresh === 1'b1)
				n_fresh++;
			if (expected_outs.size() == 0) begin
				note_mismatch("unexpected result", '0, {result_ch.filtered, result_ch.fresh});
			end else begin
				head_out = expected_outs.pop_front();
				if (result_ch.filtered !== head_out.filtered || result_ch.fresh !== head_out.fresh)
					note_mismatch("result mismatch", head_out,
						{result_ch.filtered, result_ch.fresh});
			end
		end
	end

	initial begin : stim
		int row;
		int base;
		int quota;
		int unsigned roll;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] r_idx;
		logic [WV_W-1:0] r_wval;
		logic [SMP_W-1:0] r_smp;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		window_length <= LEN_W'(LEN_RESET);
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_SAMPLE;
		item_ch.weight_index <= '0;
		item_ch.weight_value <= '0;
		item_ch.sample <= '0;
		len_reg = LEN_W'(LEN_RESET);
		held_val = '0;
		for (int i = 0; i < NWIN; i++)
			wgt_loaded[i] = 1'b0;
		restagger();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < NROWS; row++) begin
			if (dir_rows[row].cfg) begin
				write_len(dir_rows[row].len);
			end else begin
				if (dir_rows[row].cmd == CMD_SAMPLE)
					load_missing();
				send_item(dir_rows[row].cmd, dir_rows[row].idx, dir_rows[row].wval,
					dir_rows[row].smp, dir_rows[row].typed, dir_rows[row].want_f,
					dir_rows[row].want_fresh);
			end
		end

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: len = LEN_W'($urandom_range(0, LEN_MIN - 1));
				1: len = LEN_W'($urandom_range(NWIN, LEN_TOP));
				2: len = LEN_W'($urandom_range(65, 300));
				default: len = LEN_W'($urandom_range(LEN_MIN, 64));
			endcase
			write_len(len);
			if ($urandom_range(0, 1))
				send_item(CMD_RESTART, IDX_W'($urandom_range(0, 12'hfff)),
					WV_W'($urandom_range(0, 16'hffff)), SMP_W'($urandom_range(0, 16'hffff)),
					1'b0, '0, 1'b0);
			// long windows need many weight loads per sample, keep those phases short
			quota = (win_len() > 256) ? 24 : 60;
			repeat (quota) begin
				r_idx = IDX_W'($urandom_range(0, 12'hfff));
				r_wval = WV_W'($urandom_range(0, 16'hffff));
				r_smp = SMP_W'($urandom_range(0, 16'hffff));
				roll = $urandom_range(0, 99);
				if (roll < 68) begin
					load_missing();
					send_item(CMD_SAMPLE, r_idx, r_wval, pick_sample(), 1'b0, '0, 1'b0);
				end else if (roll < 88) begin
					if ($urandom_range(0, 3) != 0)
						r_idx = IDX_W'($urandom_range(0, win_len() - 1));
					send_item(CMD_LOAD, r_idx, pick_weight(), r_smp, 1'b0, '0, 1'b0);
				end else if (roll < 94) begin
					send_item(CMD_RESTART, r_idx, r_wval, r_smp, 1'b0, '0, 1'b0);
				end else begin
					send_item(CMD_UNUSED, r_idx, r_wval, r_smp, 1'b0, '0, 1'b0);
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		errors += expected_outs.size();

		$display("ran %0d sample, %0d weight load, %0d restart and %0d unused-code items",
			n_by_cmd[CMD_SAMPLE], n_by_cmd[CMD_LOAD], n_by_cmd[CMD_RESTART],
			n_by_cmd[CMD_UNUSED]);
		$display("across %0d window length writes; %0d results compared, %0d fresh, %0d errors",
			n_cfg, n_results, n_fresh, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
